@@ design/pfa_pkg.sv @@
package pfa_pkg;

  localparam int NUM_FRAMES = 256;
  localparam int MAX_PROCS  = 16;
  localparam int MAX_PAGES  = 256;

  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int FCNT_W   = FRAME_W + 1;
  localparam int PAGE_W   = $clog2(MAX_PAGES);
  localparam int PCNT_W   = PAGE_W + 1;
  localparam int SLOT_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int ADDR_W   = SLOT_W + PAGE_W;
  localparam int ENTRY_W  = 1 + FRAME_W;
  localparam int DEPTH    = MAX_PROCS * MAX_PAGES;

  localparam int PSIZE_W  = 17;
  localparam int MSIZE_W  = 25;
  localparam int BYTES_W  = 24;
  localparam int PID_W    = 16;
  localparam int PNUM_W   = 8;
  localparam int FNUM_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 25;
  localparam int DIV_W    = 25;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = PSIZE_W'(32);
  localparam logic [MSIZE_W-1:0] MEMORY_SIZE_RST = MSIZE_W'(4096);

  typedef enum logic [1:0] {
    OP_CREATE    = 2'd0,
    OP_DESTROY   = 2'd1,
    OP_RESIZE    = 2'd2,
    OP_TRANSLATE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NOPID    = 3'd1,
    STAT_NOFRAMES = 3'd2,
    STAT_NOSLOT   = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic {
    CFG_PAGE_SIZE   = 1'b0,
    CFG_MEMORY_SIZE = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T_EV,
    S_D_RD,
    S_D_EV,
    S_R_DIVN,
    S_C_RD,
    S_C_EV,
    S_C_END,
    S_S_RD,
    S_S_EV,
    S_R_DIVL,
    S_F_CNT,
    S_E_RD,
    S_E_EV,
    S_P_FIND,
    S_DONE,
    S_INIT
  } state_t;

endpackage

@@ design/pfa_ram.sv @@
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/pfa_div.sv @@
module pfa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pfa_pkg::DIV_W-1:0]    num,
  input  logic [pfa_pkg::PSIZE_W-1:0]  den,
  output logic                         done,
  output logic [pfa_pkg::DIV_W-1:0]    quo
);
  import pfa_pkg::*;

  logic [DCNT_W-1:0]  cnt;
  logic               busy;
  logic [PSIZE_W-1:0] rem;
  logic [PSIZE_W-1:0] den_r;
  logic [PSIZE_W:0]   trial;
  logic               fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= DCNT_W'(DIV_W);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= fits ? PSIZE_W'(trial - {1'b0, den_r}) : trial[PSIZE_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/paged_frame_allocator_top.sv @@
// Paged frame allocator: per-process page tables over a free-frame bitmap,
// one request word in, one status word out. A small sequencer drives a shared
// restoring divider and walks the page-table memory entry by entry and the
// frame bitmap frame by frame. Create, unknown-pid and translate requests need
// no walk. Destroy walks the table, freeing each valid entry's frame. Resize
// first divides to size the request and walks the table to count used entries;
// a shrink then walks back from the end, freeing entries, while a grow does a
// second division for the usable frame limit, counts the free frames below it,
// and then fills free table entries with free frames. Input stall stays high
// until the result word is loaded into the output register. After reset the
// frame bitmap is cleared one frame per cycle, so input stall stays high until
// all 256 frames are cleared.
module paged_frame_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [pfa_pkg::PID_W-1:0]     pid,
  input  logic [pfa_pkg::BYTES_W-1:0]   size_bytes,
  input  logic [pfa_pkg::PNUM_W-1:0]    page_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfa_pkg::STATUS_W-1:0]  status,
  output logic [pfa_pkg::FNUM_W-1:0]    frame_number,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]     cfg_data
);
  import pfa_pkg::*;

  state_t state, state_next;

  logic [PSIZE_W-1:0] page_size;
  logic [MSIZE_W-1:0] memory_size;
  logic [PSIZE_W-1:0] eff_pg;

  logic [MAX_PROCS-1:0]  slot_used;
  logic [PID_W-1:0]      slot_owner   [MAX_PROCS];
  logic [PCNT_W-1:0]     table_length [MAX_PROCS];

  logic [SLOT_W-1:0] slot_r, slot_r_next;
  logic [PCNT_W-1:0] len_r, len_r_next;
  logic [PCNT_W-1:0] idx, idx_next;
  logic [PCNT_W-1:0] used_cnt, used_cnt_next;
  logic [PCNT_W-1:0] need_r, need_r_next;
  logic              need_big, need_big_next;
  logic [PCNT_W-1:0] drop, drop_next;
  logic [PCNT_W-1:0] add, add_next;
  logic [FCNT_W-1:0] lim, lim_next;
  logic [FCNT_W-1:0] fptr, fptr_next;
  logic [FCNT_W-1:0] freec, freec_next;
  logic [FCNT_W-1:0] fc_sum;
  status_t           stat_r, stat_r_next;
  logic [FNUM_W-1:0] frm_r, frm_r_next;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ent_valid;
  logic [FRAME_W-1:0]  ent_frame;

  logic               frame_we;
  logic [FRAME_W-1:0] frame_addr;
  logic               frame_wdata;
  logic               frame_rdata;

  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;

  logic               len_we;
  logic [PCNT_W-1:0]  len_wval;
  logic               slot_set, slot_clr;
  logic               out_load;

  assign eff_pg    = (page_size == '0) ? PSIZE_W'(1) : page_size;
  assign ent_valid = ram_rdata[ENTRY_W-1];
  assign ent_frame = ram_rdata[FRAME_W-1:0];
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    free_any  = 1'b0;
    free_slot = '0;
    for (int s = MAX_PROCS - 1; s >= 0; s--) begin
      if (slot_used[s] && slot_owner[s] == pid) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
      if (!slot_used[s]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(s);
      end
    end
  end

  pfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pfa_ram #(
    .WIDTH (1),
    .DEPTH (NUM_FRAMES)
  ) u_bitmap (
    .clk   (clk),
    .we    (frame_we),
    .addr  (frame_addr),
    .wdata (frame_wdata),
    .rdata (frame_rdata)
  );

  pfa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (eff_pg),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next    = state;
    slot_r_next   = slot_r;
    len_r_next    = len_r;
    idx_next      = idx;
    used_cnt_next = used_cnt;
    need_r_next   = need_r;
    need_big_next = need_big;
    drop_next     = drop;
    add_next      = add;
    lim_next      = lim;
    fptr_next     = fptr;
    freec_next    = freec;
    fc_sum        = freec;
    stat_r_next   = stat_r;
    frm_r_next    = frm_r;
    ram_we        = 1'b0;
    ram_addr      = {slot_r, idx[PAGE_W-1:0]};
    ram_wdata     = '0;
    div_start     = 1'b0;
    div_num       = '0;
    frame_we      = 1'b0;
    frame_addr    = fptr[FRAME_W-1:0];
    frame_wdata   = 1'b0;
    len_we        = 1'b0;
    len_wval      = '0;
    slot_set      = 1'b0;
    slot_clr      = 1'b0;

    case (state)
      S_INIT: begin
        frame_we  = 1'b1;
        fptr_next = fptr + FCNT_W'(1);
        if (fptr == FCNT_W'(NUM_FRAMES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          slot_r_next = hit_slot;
          len_r_next  = table_length[hit_slot];
          idx_next    = '0;
          frm_r_next  = '0;
          stat_r_next = STAT_OK;
          if (op_t'(op) == OP_CREATE) begin
            if (!hit) begin
              if (free_any) begin
                slot_set = 1'b1;
              end else begin
                stat_r_next = STAT_NOSLOT;
              end
            end
            state_next = S_DONE;
          end else if (!hit) begin
            stat_r_next = STAT_NOPID;
            state_next  = S_DONE;
          end else begin
            case (op_t'(op))
              OP_DESTROY: begin
                state_next = S_D_RD;
              end
              OP_RESIZE: begin
                div_start  = 1'b1;
                div_num    = DIV_W'(size_bytes) + DIV_W'(eff_pg) - DIV_W'(1);
                state_next = S_R_DIVN;
              end
              default: begin
                ram_addr = {hit_slot, page_number[PAGE_W-1:0]};
                if (PCNT_W'(page_number) >= table_length[hit_slot]) begin
                  stat_r_next = STAT_RANGE;
                  state_next  = S_DONE;
                end else begin
                  state_next = S_T_EV;
                end
              end
            endcase
          end
        end
      end

      S_T_EV: begin
        frm_r_next = FNUM_W'(ent_frame);
        state_next = S_DONE;
      end

      S_D_RD: begin
        if (idx == len_r) begin
          len_we     = 1'b1;
          len_wval   = '0;
          slot_clr   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_D_EV;
        end
      end

      S_D_EV: begin
        frame_addr = ent_frame;
        frame_we   = ent_valid;
        idx_next   = idx + PCNT_W'(1);
        state_next = S_D_RD;
      end

      S_R_DIVN: begin
        if (div_done) begin
          need_big_next = (div_quo[DIV_W-1:PCNT_W] != '0);
          need_r_next   = div_quo[PCNT_W-1:0];
          used_cnt_next = '0;
          state_next    = S_C_RD;
        end
      end

      S_C_RD: begin
        state_next = (idx == len_r) ? S_C_END : S_C_EV;
      end

      S_C_EV: begin
        used_cnt_next = used_cnt + PCNT_W'(ent_valid);
        idx_next      = idx + PCNT_W'(1);
        state_next    = S_C_RD;
      end

      S_C_END: begin
        if (!need_big && need_r < used_cnt) begin
          drop_next  = used_cnt - need_r;
          idx_next   = len_r;
          state_next = S_S_RD;
        end else if (!need_big && need_r == used_cnt) begin
          state_next = S_DONE;
        end else if (need_big || need_r > PCNT_W'(MAX_PAGES)) begin
          stat_r_next = STAT_NOFRAMES;
          state_next  = S_DONE;
        end else begin
          add_next   = need_r - used_cnt;
          div_start  = 1'b1;
          div_num    = DIV_W'(memory_size);
          state_next = S_R_DIVL;
        end
      end

      S_S_RD: begin
        if (drop == '0 || idx == '0) begin
          state_next = S_DONE;
        end else begin
          ram_addr   = {slot_r, PAGE_W'(idx - PCNT_W'(1))};
          idx_next   = idx - PCNT_W'(1);
          state_next = S_S_EV;
        end
      end

      S_S_EV: begin
        if (ent_valid) begin
          ram_we     = 1'b1;
          ram_wdata  = {1'b0, ent_frame};
          frame_addr = ent_frame;
          frame_we   = 1'b1;
          drop_next  = drop - PCNT_W'(1);
        end
        state_next = S_S_RD;
      end

      S_R_DIVL: begin
        if (div_done) begin
          lim_next   = (div_quo > DIV_W'(NUM_FRAMES)) ? FCNT_W'(NUM_FRAMES)
                                                      : div_quo[FCNT_W-1:0];
          fptr_next  = '0;
          freec_next = '0;
          state_next = S_F_CNT;
        end
      end

      S_F_CNT: begin
        fc_sum = freec + FCNT_W'((fptr != '0) && !frame_rdata);
        if (fptr == lim) begin
          if (fc_sum < FCNT_W'(add)) begin
            stat_r_next = STAT_NOFRAMES;
            state_next  = S_DONE;
          end else begin
            idx_next   = '0;
            fptr_next  = '0;
            state_next = S_E_RD;
          end
        end else begin
          freec_next = fc_sum;
          fptr_next  = fptr + FCNT_W'(1);
        end
      end

      S_E_RD: begin
        if (idx == len_r) begin
          len_r_next = len_r + PCNT_W'(1);
          len_we     = 1'b1;
          len_wval   = len_r + PCNT_W'(1);
          state_next = S_P_FIND;
        end else begin
          state_next = S_E_EV;
        end
      end

      S_E_EV: begin
        if (ent_valid) begin
          idx_next   = idx + PCNT_W'(1);
          state_next = S_E_RD;
        end else begin
          state_next = S_P_FIND;
        end
      end

      S_P_FIND: begin
        if (frame_rdata) begin
          fptr_next  = fptr + FCNT_W'(1);
          frame_addr = FRAME_W'(fptr + FCNT_W'(1));
        end else begin
          ram_we      = 1'b1;
          ram_wdata   = {1'b1, fptr[FRAME_W-1:0]};
          frame_we    = 1'b1;
          frame_wdata = 1'b1;
          add_next    = add - PCNT_W'(1);
          idx_next    = idx + PCNT_W'(1);
          fptr_next   = fptr + FCNT_W'(1);
          state_next  = (add == PCNT_W'(1)) ? S_DONE : S_E_RD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      fptr  <= '0;
    end else begin
      state <= state_next;
      fptr  <= fptr_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_r_next;
    len_r    <= len_r_next;
    idx      <= idx_next;
    used_cnt <= used_cnt_next;
    need_r   <= need_r_next;
    need_big <= need_big_next;
    drop     <= drop_next;
    add      <= add_next;
    lim      <= lim_next;
    freec    <= freec_next;
    stat_r   <= stat_r_next;
    frm_r    <= frm_r_next;
    if (slot_set) begin
      slot_owner[free_slot] <= pid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used    <= '0;
      for (int s = 0; s < MAX_PROCS; s++) begin
        table_length[s] <= '0;
      end
      page_size    <= PAGE_SIZE_RST;
      memory_size  <= MEMORY_SIZE_RST;
    end else begin
      if (slot_set) begin
        slot_used[free_slot] <= 1'b1;
      end
      if (slot_clr) begin
        slot_used[slot_r] <= 1'b0;
      end
      if (len_we) begin
        table_length[slot_r] <= len_wval;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PAGE_SIZE:   page_size   <= cfg_data[PSIZE_W-1:0];
          CFG_MEMORY_SIZE: memory_size <= cfg_data[MSIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= stat_r;
      frame_number <= frm_r;
    end
  end

endmodule

@@ verif/paged_frame_allocator_checker.sv @@
module paged_frame_allocator_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [pfa_pkg::PID_W-1:0]    pid,
  input  logic [pfa_pkg::BYTES_W-1:0]  size_bytes,
  input  logic [pfa_pkg::PNUM_W-1:0]   page_number,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [pfa_pkg::STATUS_W-1:0] status,
  input  logic [pfa_pkg::FNUM_W-1:0]   frame_number,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]    cfg_data,
  output int                           errors,
  output int                           pending
);
  import pfa_pkg::*;

  typedef struct packed {
    status_t           st;
    logic [FNUM_W-1:0] frame;
  } reply_t;

  reply_t replies_due[$];

  logic                frame_busy [NUM_FRAMES];
  logic                slot_live  [MAX_PROCS];
  logic [PID_W-1:0]    slot_pid   [MAX_PROCS];
  int                  tab_len    [MAX_PROCS];
  logic                ent_live   [MAX_PROCS][MAX_PAGES];
  logic [FNUM_W-1:0]   ent_frame  [MAX_PROCS][MAX_PAGES];
  logic [PSIZE_W-1:0]  pg_size;
  logic [MSIZE_W-1:0]  mem_size;
  int                  err_cnt = 0;

  function automatic longint page_bytes();
    return (pg_size == 0) ? 1 : longint'(pg_size);
  endfunction

  function automatic int frame_limit();
    longint n;
    n = longint'(mem_size) / page_bytes();
    return (n > NUM_FRAMES) ? NUM_FRAMES : int'(n);
  endfunction

  function automatic int owner_slot(logic [PID_W-1:0] p);
    for (int s = 0; s < MAX_PROCS; s++)
      if (slot_live[s] && slot_pid[s] == p) return s;
    return -1;
  endfunction

  task automatic free_table(int s);
    for (int i = 0; i < MAX_PAGES; i++) begin
      if (ent_live[s][i]) begin
        frame_busy[ent_frame[s][i]] = 1'b0;
        ent_live[s][i] = 1'b0;
      end
    end
    tab_len[s] = 0;
  endtask

  task automatic resize_proc(int s, logic [BYTES_W-1:0] bytes, output status_t st);
    longint need;
    int used, drop, i, add, lim, freec, e, f;
    need = (longint'(bytes) + page_bytes() - 1) / page_bytes();
    used = 0;
    st = STAT_OK;
    for (i = 0; i < tab_len[s]; i++)
      if (ent_live[s][i]) used++;
    if (need < used) begin
      drop = used - int'(need);
      i = tab_len[s];
      while (drop > 0 && i > 0) begin
        i--;
        if (ent_live[s][i]) begin
          frame_busy[ent_frame[s][i]] = 1'b0;
          ent_live[s][i] = 1'b0;
          drop--;
        end
      end
    end else if (need > used) begin
      if (need > MAX_PAGES) begin
        st = STAT_NOFRAMES;
      end else begin
        add = int'(need) - used;
        lim = frame_limit();
        freec = 0;
        for (i = 0; i < lim; i++)
          if (!frame_busy[i]) freec++;
        if (freec < add) begin
          st = STAT_NOFRAMES;
        end else begin
          for (int k = 0; k < add; k++) begin
            e = 0;
            f = 0;
            while (e < tab_len[s] && ent_live[s][e]) e++;
            if (e == tab_len[s]) tab_len[s]++;
            while (f < lim && frame_busy[f]) f++;
            frame_busy[f] = 1'b1;
            ent_live[s][e] = 1'b1;
            ent_frame[s][e] = FNUM_W'(f);
          end
        end
      end
    end
  endtask

  task automatic predict_request();
    reply_t r;
    int s;
    status_t st;
    r.st = STAT_OK;
    r.frame = '0;
    s = owner_slot(pid);
    if (op_t'(op) == OP_CREATE) begin
      if (s < 0) begin
        r.st = STAT_NOSLOT;
        for (int t = 0; t < MAX_PROCS; t++) begin
          if (!slot_live[t]) begin
            free_table(t);
            slot_live[t] = 1'b1;
            slot_pid[t] = pid;
            r.st = STAT_OK;
            break;
          end
        end
      end
    end else if (s < 0) begin
      r.st = STAT_NOPID;
    end else if (op_t'(op) == OP_DESTROY) begin
      free_table(s);
      slot_live[s] = 1'b0;
    end else if (op_t'(op) == OP_RESIZE) begin
      resize_proc(s, size_bytes, st);
      r.st = st;
    end else begin
      if (int'(page_number) >= tab_len[s]) r.st = STAT_RANGE;
      else r.frame = ent_frame[s][page_number];
    end
    replies_due.push_back(r);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      replies_due.delete();
      for (int f = 0; f < NUM_FRAMES; f++) frame_busy[f] = 1'b0;
      for (int s = 0; s < MAX_PROCS; s++) begin
        slot_live[s] = 1'b0;
        tab_len[s] = 0;
        for (int i = 0; i < MAX_PAGES; i++) ent_live[s][i] = 1'b0;
      end
      pg_size = PAGE_SIZE_RST;
      mem_size = MEMORY_SIZE_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_idx_t'(cfg_index) == CFG_PAGE_SIZE) pg_size = cfg_data[PSIZE_W-1:0];
        else mem_size = cfg_data[MSIZE_W-1:0];
      end
      if (in_valid && !in_stall) predict_request();
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word status=%0d frame=%0d", $time, status,
                   frame_number);
        end else begin
          want = replies_due.pop_front();
          if (status !== want.st) begin
            err_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          end
          if (frame_number !== want.frame) begin
            err_cnt++;
            $display("%0t: frame expected %0d actual %0d", $time, want.frame,
                     frame_number);
          end
        end
      end
    end
    pending <= replies_due.size();
    errors <= err_cnt;
  end

endmodule

@@ verif/paged_frame_allocator_top_tb.sv @@
module paged_frame_allocator_top_tb;
  import pfa_pkg::*;

  localparam int LIMIT = 4000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          op = '0;
  logic [PID_W-1:0]    pid = '0;
  logic [BYTES_W-1:0]  size_bytes = '0;
  logic [PNUM_W-1:0]   page_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [FNUM_W-1:0]   frame_number;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  int                  errors;
  int                  pending;

  logic                tx_gaps = 1'b1;
  logic                rx_gaps = 1'b1;
  logic                rx_hold_go = 1'b0;
  int                  rx_hold_cnt = 0;
  int                  cycles = 0;
  logic [PID_W-1:0]    pids [24];
  longint              cur_page = 32;

  paged_frame_allocator_top i_dut (.*);

  paged_frame_allocator_checker i_checker (.*);

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold_cnt > 0) begin
      out_stall <= 1'b1;
      rx_hold_cnt <= rx_hold_cnt - 1;
    end else if (rx_hold_go) begin
      out_stall <= 1'b1;
      rx_hold_cnt <= 3000;
    end else begin
      out_stall <= rx_gaps && ($urandom_range(0, 99) < 37);
    end
  end

  task automatic send_word(op_t o, logic [PID_W-1:0] p, logic [BYTES_W-1:0] b,
                           logic [PNUM_W-1:0] pg);
    in_valid <= 1'b1;
    op <= o;
    pid <= p;
    size_bytes <= b;
    page_number <= pg;
    do @(posedge clk); while (in_stall);
    if (tx_gaps && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(longint ps, longint ms);
    write_cfg(CFG_PAGE_SIZE, CFG_W'(ps));
    write_cfg(CFG_MEMORY_SIZE, CFG_W'(ms));
    cur_page = (ps == 0) ? 1 : ps;
  endtask

  task automatic random_words(int n);
    int r;
    longint top_sz;
    logic [PID_W-1:0] p;
    logic [BYTES_W-1:0] b;
    logic [PNUM_W-1:0] pg;
    for (int i = 0; i < n; i++) begin
      p = ($urandom_range(0, 9) == 0) ? PID_W'($urandom) : pids[$urandom_range(0, 23)];
      top_sz = cur_page * 40;
      if (top_sz > 16777215) top_sz = 16777215;
      b = ($urandom_range(0, 9) == 0) ? BYTES_W'($urandom)
                                       : BYTES_W'($urandom_range(0, int'(top_sz)));
      pg = ($urandom_range(0, 4) == 0) ? PNUM_W'($urandom) : PNUM_W'($urandom_range(0, 40));
      r = $urandom_range(0, 99);
      if (r < 20) send_word(OP_CREATE, p, b, pg);
      else if (r < 33) send_word(OP_DESTROY, p, b, pg);
      else if (r < 68) send_word(OP_RESIZE, p, b, pg);
      else send_word(OP_TRANSLATE, p, b, pg);
    end
  endtask

  initial begin
    pids[0] = '0;
    pids[1] = '1;
    for (int i = 2; i < 24; i++) pids[i] = PID_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_CREATE, 16'd0, '0, '0);
    send_word(OP_CREATE, 16'hFFFF, '0, '0);
    send_word(OP_CREATE, 16'd0, '0, '0);
    send_word(OP_TRANSLATE, 16'd5, '0, '0);
    send_word(OP_RESIZE, 16'd0, 24'd0, '0);
    send_word(OP_RESIZE, 16'd0, 24'd100, '0);
    send_word(OP_TRANSLATE, 16'd0, '0, 8'd3);
    send_word(OP_TRANSLATE, 16'd0, '0, 8'd4);
    send_word(OP_TRANSLATE, 16'd0, '0, 8'd255);
    send_word(OP_RESIZE, 16'd0, 24'd33, '0);
    send_word(OP_TRANSLATE, 16'd0, '0, 8'd3);
    send_word(OP_RESIZE, 16'd0, 24'hFFFFFF, '0);
    send_word(OP_RESIZE, 16'hFFFF, 24'd4096, '0);
    send_word(OP_RESIZE, 16'd0, 24'd8192, '0);
    send_word(OP_TRANSLATE, 16'hFFFF, '0, 8'd127);
    for (int i = 1; i <= 14; i++) send_word(OP_CREATE, PID_W'(i), '0, '0);
    send_word(OP_CREATE, 16'd99, '0, '0);
    send_word(OP_DESTROY, 16'd0, '0, '0);
    send_word(OP_DESTROY, 16'd0, '0, '0);
    for (int i = 1; i <= 14; i++) send_word(OP_DESTROY, PID_W'(i), '0, '0);
    drain();

    random_words(80);
    drain();

    set_mode(1, 16777215);
    random_words(80);
    drain();

    set_mode(65536, 16777216);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_words(80);
    drain();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    set_mode(0, 1);
    random_words(40);
    drain();

    set_mode(16, 100);
    rx_hold_go <= 1'b1;
    @(posedge clk);
    rx_hold_go <= 1'b0;
    random_words(80);
    drain();

    set_mode($urandom_range(1, 131071), $urandom_range(1, 33554431));
    random_words(40);
    drain();

    set_mode(32, 4096);
    random_words(60);
    drain();

    repeat (2000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
